### rtl/hdrlw_pkg.sv
`timescale 1ns / 1ps

package hdrlw_pkg;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // ASCII characters of the record line
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Record type of a data record
    localparam logic [7:0] REC_TYPE_DATA = 8'h00;

    // Characters of a record line, colon and CR LF included, apart from two per data byte
    localparam logic [9:0] LINE_FIXED_LEN = 10'd13;

    // Command queue between front and back
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_COUNT_W = $clog2(CMD_DEPTH + 1);

    // Last step of the header and data parts, and number of trailer steps, in the back end
    localparam logic [3:0] HDR_LAST_STEP  = 4'd8;
    localparam logic [3:0] DATA_LAST_STEP = 4'd1;
    localparam logic [3:0] TRAILER_STEPS  = 4'd5;

    typedef enum logic
    {
        CMD_HEADER,
        CMD_DATA
    } cmd_kind_t;

    // One unit of work for the back end
    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [7:0]  count;
        logic [15:0] address;
        logic [7:0]  data;
        logic        trailer;
        logic [7:0]  checksum;
        logic [9:0]  length;
    } cmd_t;

    // Upper-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

### rtl/hdrlw_front.sv
`timescale 1ns / 1ps

module hdrlw_front
    import hdrlw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        operation,
    input  logic [15:0] load_address,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  data_byte,
    output logic        cmd_push,
    output cmd_t        cmd
);

    logic       record_open_reg, record_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] record_size_reg, record_size_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic [7:0] header_sum;
    logic [7:0] data_sum;
    logic       data_ok;

    assign header_sum = byte_count + load_address[15:8] + load_address[7:0] + REC_TYPE_DATA;
    assign data_sum   = running_sum_reg + data_byte;
    assign data_ok    = record_open_reg && (bytes_left_reg != 8'd0);

    // Classify the beat and update record state
    always_comb
    begin
        record_open_next = record_open_reg;
        bytes_left_next  = bytes_left_reg;
        record_size_next = record_size_reg;
        running_sum_next = running_sum_reg;
        cmd_push         = 1'b0;
        cmd.kind         = CMD_HEADER;
        cmd.count        = byte_count;
        cmd.address      = load_address;
        cmd.data         = data_byte;
        cmd.trailer      = 1'b0;
        cmd.checksum     = 8'd0;
        cmd.length       = 10'd0;
        if (accept)
        begin
            if (operation == OP_START)
            begin
                record_open_next = (byte_count != 8'd0);
                bytes_left_next  = byte_count;
                record_size_next = byte_count;
                running_sum_next = header_sum;
                cmd_push         = 1'b1;
                cmd.kind         = CMD_HEADER;
                cmd.trailer      = (byte_count == 8'd0);
                cmd.checksum     = 8'd0 - header_sum;
                cmd.length       = {1'b0, byte_count, 1'b0} + LINE_FIXED_LEN;
            end
            else if (data_ok)
            begin
                running_sum_next = data_sum;
                bytes_left_next  = bytes_left_reg - 8'd1;
                cmd_push         = 1'b1;
                cmd.kind         = CMD_DATA;
                cmd.trailer      = (bytes_left_reg == 8'd1);
                cmd.checksum     = 8'd0 - data_sum;
                cmd.length       = {1'b0, record_size_reg, 1'b0} + LINE_FIXED_LEN;
                if (bytes_left_reg == 8'd1)
                begin
                    record_open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_open_reg <= 1'b0;
            bytes_left_reg  <= 8'd0;
            record_size_reg <= 8'd0;
            running_sum_reg <= 8'd0;
        end
        else
        begin
            record_open_reg <= record_open_next;
            bytes_left_reg  <= bytes_left_next;
            record_size_reg <= record_size_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // An open record always expects at least one more byte
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        record_open_reg |-> (bytes_left_reg != 8'd0))
        else $error("open record with no bytes left");

endmodule

### rtl/hdrlw_cmd_fifo.sv
`timescale 1ns / 1ps

module hdrlw_cmd_fifo
    import hdrlw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic rd_valid
);

    cmd_t mem [CMD_DEPTH];

    logic [CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_COUNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CMD_COUNT_W'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !rd_valid))
        else $error("command queue underflow");

endmodule

### rtl/hdrlw_back.sv
`timescale 1ns / 1ps

module hdrlw_back
    import hdrlw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] text_char,
    output logic       line_done,
    output logic [9:0] line_length
);

    cmd_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [3:0] step_reg, step_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_done_reg, out_done_next;
    logic [9:0] out_len_reg, out_len_next;

    logic [3:0] body_last;
    logic [3:0] last_step;
    logic [3:0] trail_idx;
    logic       emit;
    logic       finish;
    logic       load;

    // Step bounds of the current command
    assign body_last = (cur_reg.kind == CMD_HEADER) ? HDR_LAST_STEP : DATA_LAST_STEP;
    assign last_step = cur_reg.trailer ? (body_last + TRAILER_STEPS) : body_last;
    assign trail_idx = step_reg - body_last - 4'd1;

    assign emit    = cur_valid_reg && (!out_valid_reg || pop);
    assign finish  = emit && (step_reg == last_step);
    assign load    = cmd_valid && (!cur_valid_reg || finish);
    assign cmd_pop = load;

    // Character of the current step
    always_comb
    begin
        out_char_next = CHAR_NUL;
        out_done_next = 1'b0;
        out_len_next  = 10'd0;
        if (step_reg <= body_last)
        begin
            if (cur_reg.kind == CMD_HEADER)
            begin
                case (step_reg)
                    4'd0:    out_char_next = CHAR_COLON;
                    4'd1:    out_char_next = hex_char(cur_reg.count[7:4]);
                    4'd2:    out_char_next = hex_char(cur_reg.count[3:0]);
                    4'd3:    out_char_next = hex_char(cur_reg.address[15:12]);
                    4'd4:    out_char_next = hex_char(cur_reg.address[11:8]);
                    4'd5:    out_char_next = hex_char(cur_reg.address[7:4]);
                    4'd6:    out_char_next = hex_char(cur_reg.address[3:0]);
                    4'd7:    out_char_next = hex_char(REC_TYPE_DATA[7:4]);
                    default: out_char_next = hex_char(REC_TYPE_DATA[3:0]);
                endcase
            end
            else if (step_reg == 4'd0)
            begin
                out_char_next = hex_char(cur_reg.data[7:4]);
            end
            else
            begin
                out_char_next = hex_char(cur_reg.data[3:0]);
            end
        end
        else
        begin
            case (trail_idx)
                4'd0:    out_char_next = hex_char(cur_reg.checksum[7:4]);
                4'd1:    out_char_next = hex_char(cur_reg.checksum[3:0]);
                4'd2:    out_char_next = CHAR_CR;
                4'd3:    out_char_next = CHAR_LF;
                default:
                begin
                    out_char_next = CHAR_NUL;
                    out_done_next = 1'b1;
                    out_len_next  = cur_reg.length;
                end
            endcase
        end
    end

    // Sequencing of commands and steps
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (load)
        begin
            cur_next       = cmd;
            cur_valid_next = 1'b1;
            step_next      = 4'd0;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
            step_next      = 4'd0;
        end
        else if (emit)
        begin
            step_next = step_reg + 4'd1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_char_reg <= out_char_next;
            out_done_reg <= out_done_next;
            out_len_reg  <= out_len_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign text_char   = out_char_reg;
    assign line_done   = out_done_reg;
    assign line_length = out_len_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (step_reg <= last_step))
        else $error("step counter ran past the command");

    a_done_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_done) |-> (text_char == CHAR_NUL && line_length != 10'd0))
        else $error("line end beat is not a NUL with a length");

    a_len_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !line_done) |-> (line_length == 10'd0))
        else $error("line length on a non-final beat");

endmodule

### rtl/hex_data_record_line_writer.sv
`timescale 1ns / 1ps

// Intel HEX data record line writer.
// Input queue: a beat is taken when push is high and full is low. A start
// beat (operation 0) opens a record with load_address and byte_count and
// yields ':', count, address and type "00" as hex text (9 characters). A
// data beat yields two hex characters; after the last counted byte (or at
// once for a zero count) the checksum, CR, LF and a NUL follow. Data beats
// with no open record are taken and dropped.
// Output queue: one character per beat while empty is low, taken on pop.
// line_done and line_length (2n+13) are set on the closing NUL only.
// A beat passes the command queue, current command and output registers.
// One character per cycle while pop is high, set by the single output
// register; a data beat gives 2 characters (7 with trailer), a start 9 (14).
// A four-entry command queue sits between the classifier and the character
// sequencer, so input beats keep being taken while the receiver stalls until
// that queue fills; then full stays high until pop frees space.
// Reset empties both queues and closes any open record.

module hex_data_record_line_writer
    import hdrlw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [15:0] load_address,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  text_char,
    output logic        line_done,
    output logic [9:0]  line_length
);

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_valid;

    assign accept = push && !full;

    hdrlw_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .load_address (load_address),
        .byte_count   (byte_count),
        .data_byte    (data_byte),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    hdrlw_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (cmd_in),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_cmd   (cmd_out),
        .rd_valid (cmd_valid)
    );

    hdrlw_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .text_char   (text_char),
        .line_done   (line_done),
        .line_length (line_length)
    );

endmodule
